/* rtl/hbf_pkg.sv */
// ----------------------------------------------------------------------------
// hbf_pkg
// shared types and constants of the harmonic bond force pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package hbf_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int SQ_STEPS    = 32;
	localparam int DIV_BITS    = 64;

	localparam logic [1:0] REG_NEWTON = 2'd0;
	localparam logic [1:0] REG_ENERGY = 2'd1;
	localparam logic [1:0] REG_VIRIAL = 2'd2;

	typedef struct packed {
		logic newton;
		logic energy;
		logic virial;
	} cfg_t;

	// rounded quotient job carried through a divider pipe
	typedef struct packed {
		logic [127:0] num;
		logic [63:0]  den;
		logic         neg;
		logic         zero;
	} div_job_t;

	function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
		logic [31:0] res;
		if (neg) begin
			if (mag >= 64'h8000_0000) res = 32'h8000_0000;
			else res = 32'(~mag[31:0] + 32'd1);
		end else begin
			if (mag > 64'h7FFF_FFFF) res = 32'h7FFF_FFFF;
			else res = mag[31:0];
		end
		return res;
	endfunction
endpackage
`default_nettype wire

/* rtl/harmonic_bond_force.sv */
// ----------------------------------------------------------------------------
// harmonic_bond_force
// harmonic bond force, energy and virial, one bond per cycle
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// bond      in         start / busy       positions, stiffness, rest length, locality
// result    out        done strobe        force, apply flags, energy, virial
// config    in         cfg_valid/ready    cfg_index, cfg_data
//
// one bond per cycle; between the bond transfer and done lie
// 3 delta and square stages + 32 root stages + 4 product stages
// + 64 divider stages + 1 output register
// busy is always low; the result is a one-cycle done strobe, never held off
// reset clears the valid pipe and sets newton mode, energy and virial off
`default_nettype none
module harmonic_bond_force (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [31:0]  first_x,
	input  wire logic [31:0]  first_y,
	input  wire logic [31:0]  first_z,
	input  wire logic [31:0]  second_x,
	input  wire logic [31:0]  second_y,
	input  wire logic [31:0]  second_z,
	input  wire logic [30:0]  stiffness,
	input  wire logic [30:0]  rest_length,
	input  wire logic         first_is_local,
	input  wire logic         second_is_local,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output logic              done,
	output logic [31:0]       force_x,
	output logic [31:0]       force_y,
	output logic [31:0]       force_z,
	output logic              apply_first,
	output logic              apply_second,
	output logic [30:0]       energy_tally,
	output logic [31:0]       virial_xx,
	output logic [31:0]       virial_yy,
	output logic [31:0]       virial_zz,
	output logic [31:0]       virial_xy,
	output logic [31:0]       virial_xz,
	output logic [31:0]       virial_yz
);
	import hbf_pkg::*;

	localparam int SQL = SQ_STEPS;
	localparam int DVL = DIV_BITS;

	cfg_t cfg_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{newton: 1'b1, energy: 1'b0, virial: 1'b0};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NEWTON: cfg_q.newton <= cfg_data[0];
				REG_ENERGY: cfg_q.energy <= cfg_data[0];
				REG_VIRIAL: cfg_q.virial <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: saturated deltas
	logic        v_s1;
	logic [31:0] mag_s1 [3];
	logic [2:0]  ng_s1;
	logic [30:0] k_s1, r0_s1;
	logic [1:0]  c_s1;
	logic        af_s1, as_s1, en_s1, vi_s1;
	logic [31:0] pa [3];
	logic [31:0] pb [3];

	assign pa[0] = first_x;  assign pa[1] = first_y;  assign pa[2] = first_z;
	assign pb[0] = second_x; assign pb[1] = second_y; assign pb[2] = second_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	for (genvar i = 0; i < 3; i++) begin : g_d
		logic signed [32:0] ea, eb, t;
		logic signed [31:0] ts;
		assign ea = 33'(signed'(pa[i][CW-1:0]));
		assign eb = 33'(signed'(pb[i][CW-1:0]));
		assign t  = ea - eb;
		always_comb begin
			if (t > 33'sh0_7FFF_FFFF) ts = 32'sh7FFF_FFFF;
			else if (t < -33'sh0_8000_0000) ts = 32'sh8000_0000;
			else ts = t[31:0];
		end
		always_ff @(posedge clk) begin
			ng_s1[i]  <= ts[31];
			mag_s1[i] <= ts[31] ? 32'(-ts) : ts;
		end
	end

	always_ff @(posedge clk) begin
		k_s1  <= stiffness;
		r0_s1 <= rest_length;
		c_s1  <= cfg_q.newton ? 2'd2 : 2'(first_is_local) + 2'(second_is_local);
		af_s1 <= cfg_q.newton | first_is_local;
		as_s1 <= cfg_q.newton | second_is_local;
		en_s1 <= cfg_q.energy;
		vi_s1 <= cfg_q.virial;
	end

	// stage 2: squares and cross products
	logic        v_s2;
	logic [63:0] sq_s2 [3];
	logic [63:0] xp_s2 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) sq_s2[i] <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
		xp_s2[0] <= 64'(mag_s1[0]) * 64'(mag_s1[1]);
		xp_s2[1] <= 64'(mag_s1[0]) * 64'(mag_s1[2]);
		xp_s2[2] <= 64'(mag_s1[1]) * 64'(mag_s1[2]);
	end

	// stage 3: sum of squares
	logic        v_s3;
	logic [63:0] rsq_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		rsq_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	logic        sq_valid;
	logic [31:0] root;
	hbf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.rsq       (rsq_s3),
		.out_valid (sq_valid),
		.root      (root)
	);

	// side data delayed across the root pipe
	localparam int SW = 96 + 192 + 3 + 62 + 2 + 4;
	logic [SW-1:0] side_in;
	logic [SW-1:0] side_q [SQL+2];
	assign side_in = {mag_s1[0], mag_s1[1], mag_s1[2], 192'd0, ng_s1,
		k_s1, r0_s1, c_s1, af_s1, as_s1, en_s1, vi_s1};
	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		side_q[1] <= {side_q[0][SW-1:SW-96], xp_s2[0], xp_s2[1], xp_s2[2],
			side_q[0][SW-289:0]};
		for (int i = 2; i < SQL + 2; i++) side_q[i] <= side_q[i-1];
	end
	logic [SW-1:0] sd;
	assign sd = side_q[SQL+1];

	logic [31:0] m4 [3];
	logic [63:0] x4 [3];
	logic [2:0]  n4;
	logic [30:0] k4, r04;
	logic [1:0]  c4;
	logic        af4, as4, en4, vi4;
	assign {m4[0], m4[1], m4[2], x4[0], x4[1], x4[2], n4, k4, r04, c4,
		af4, as4, en4, vi4} = sd;

	// stage 4: dr
	logic        v_s4, drn_s4;
	logic [31:0] adr_s4, r_s4;
	logic [31:0] m_s4 [3];
	logic [63:0] x_s4 [3];
	logic [2:0]  n_s4;
	logic [30:0] k_s4;
	logic [1:0]  c_s4;
	logic        af_s4, as_s4, en_s4, vi_s4;
	logic signed [32:0] dr;
	assign dr = signed'({1'b0, root}) - signed'({2'b0, r04});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= sq_valid;
	end
	always_ff @(posedge clk) begin
		drn_s4 <= dr[32];
		adr_s4 <= dr[32] ? 32'(-dr) : dr[31:0];
		r_s4   <= root;
		m_s4   <= m4;
		x_s4   <= x4;
		n_s4   <= n4;
		k_s4   <= k4;
		c_s4   <= c4;
		af_s4  <= af4; as_s4 <= as4; en_s4 <= en4; vi_s4 <= vi4;
	end

	// stage 5: A = k*|dr| and virial factors
	logic        v_s5;
	logic [63:0] a_s5;
	logic [31:0] adr_s5, r_s5;
	logic [31:0] m_s5 [3];
	logic [63:0] vf_s5 [6];
	logic [2:0]  n_s5;
	logic [1:0]  c_s5;
	logic        drn_s5, af_s5, as_s5, en_s5, vi_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		a_s5   <= 64'(k_s4) * 64'(adr_s4);
		for (int i = 0; i < 3; i++) vf_s5[i] <= 64'(m_s4[i]) * 64'(m_s4[i]);
		vf_s5[3] <= x_s4[0]; vf_s5[4] <= x_s4[1]; vf_s5[5] <= x_s4[2];
		adr_s5 <= adr_s4; r_s5 <= r_s4; m_s5 <= m_s4;
		n_s5   <= n_s4; c_s5 <= c_s4; drn_s5 <= drn_s4;
		af_s5  <= af_s4; as_s5 <= as_s4; en_s5 <= en_s4; vi_s5 <= vi_s4;
	end

	// stage 6: 32 x 32 partial products of A (below 2^63) with each factor
	logic        v_s6;
	logic [63:0] pf_s6 [3][2];
	logic [63:0] pe_s6 [2];
	logic [63:0] pv_s6 [6][4];
	logic [31:0] r_s6;
	logic [2:0]  n_s6;
	logic [1:0]  c_s6;
	logic        drn_s6, af_s6, as_s6, ee_s6, ve_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pf_s6[i][0] <= 64'(a_s5[31:0]) * 64'(m_s5[i]);
			pf_s6[i][1] <= 64'(a_s5[63:32]) * 64'(m_s5[i]);
		end
		pe_s6[0] <= 64'(a_s5[31:0]) * 64'(adr_s5);
		pe_s6[1] <= 64'(a_s5[63:32]) * 64'(adr_s5);
		for (int i = 0; i < 6; i++) begin
			pv_s6[i][0] <= 64'(a_s5[31:0]) * 64'(vf_s5[i][31:0]);
			pv_s6[i][1] <= 64'(a_s5[31:0]) * 64'(vf_s5[i][63:32]);
			pv_s6[i][2] <= 64'(a_s5[63:32]) * 64'(vf_s5[i][31:0]);
			pv_s6[i][3] <= 64'(a_s5[63:32]) * 64'(vf_s5[i][63:32]);
		end
		r_s6 <= r_s5; n_s6 <= n_s5; c_s6 <= c_s5; drn_s6 <= drn_s5;
		af_s6 <= af_s5; as_s6 <= as_s5; ee_s6 <= en_s5; ve_s6 <= vi_s5;
	end

	// stage 7: sums of partial products
	logic         v_s7;
	logic [127:0] fn_s7 [3];
	logic [127:0] en_num_s7;
	logic [127:0] vn_s7 [6];
	logic [31:0]  r_s7;
	logic [2:0]   n_s7;
	logic [1:0]   c_s7;
	logic         drn_s7, af_s7, as_s7, ee_s7, ve_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			fn_s7[i] <= (128'(pf_s6[i][1]) << 33) + (128'(pf_s6[i][0]) << 1);
		en_num_s7 <= (128'(pe_s6[1]) << 32) + 128'(pe_s6[0]);
		for (int i = 0; i < 6; i++)
			vn_s7[i] <= (128'(pv_s6[i][3]) << 64) + (128'(pv_s6[i][2]) << 32)
				+ (128'(pv_s6[i][1]) << 32) + 128'(pv_s6[i][0]);
		r_s7 <= r_s6; n_s7 <= n_s6; c_s7 <= c_s6; drn_s7 <= drn_s6;
		af_s7 <= af_s6; as_s7 <= as_s6; ee_s7 <= ee_s6; ve_s7 <= ve_s6;
	end

	div_job_t jobs [9];
	logic [31:0] qs [9];
	localparam int VA [6] = '{0, 1, 2, 0, 0, 1};
	localparam int VB [6] = '{0, 1, 2, 1, 2, 2};
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			jobs[i].num  = fn_s7[i];
			jobs[i].den  = {16'd0, r_s7, 16'd0};
			jobs[i].neg  = (drn_s7 == n_s7[i]);
			jobs[i].zero = (r_s7 == '0);
		end
		for (int i = 0; i < 6; i++) begin
			jobs[3+i].num  = vn_s7[i];
			jobs[3+i].den  = (c_s7 == 2'd2) ? {1'b0, r_s7, 31'd0} : {r_s7, 32'd0};
			jobs[3+i].neg  = ((n_s7[VA[i]] != n_s7[VB[i]]) == drn_s7);
			jobs[3+i].zero = !ve_s7 || (c_s7 == 2'd0) || (r_s7 == '0);
		end
	end

	for (genvar j = 0; j < 9; j++) begin : g_div
		hbf_rdiv u_rdiv (.clk(clk), .job(jobs[j]), .quot(qs[j]));
	end

	// energy: rounded shift by 2^32 or 2^33, saturated to 31 bits
	logic [127:0] e_rnd;
	logic [95:0]  e_quo;
	logic [30:0]  e_val;
	always_comb begin
		e_rnd = en_num_s7 + ((c_s7 == 2'd2) ? 128'h8000_0000 : 128'h1_0000_0000);
		e_quo = (c_s7 == 2'd2) ? e_rnd[127:32] : {1'b0, e_rnd[127:33]};
		if (!ee_s7 || (c_s7 == 2'd0)) e_val = '0;
		else if (e_quo > 96'h7FFF_FFFF) e_val = 31'h7FFF_FFFF;
		else e_val = e_quo[30:0];
	end

	logic [DVL-1:0] dv_q;
	logic [32:0]    tail_q [DVL];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_q <= '0;
		else dv_q <= {dv_q[DVL-2:0], v_s7};
	end
	always_ff @(posedge clk) begin
		tail_q[0] <= {af_s7, as_s7, e_val};
		for (int i = 1; i < DVL; i++) tail_q[i] <= tail_q[i-1];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv_q[DVL-1];
	end
	always_ff @(posedge clk) begin
		force_x      <= qs[0];
		force_y      <= qs[1];
		force_z      <= qs[2];
		virial_xx    <= qs[3];
		virial_yy    <= qs[4];
		virial_zz    <= qs[5];
		virial_xy    <= qs[6];
		virial_xz    <= qs[7];
		virial_yz    <= qs[8];
		{apply_first, apply_second, energy_tally} <= tail_q[DVL-1];
	end

`ifndef ASSERT_OFF
	a_busy_low: assert property (@(posedge clk) busy == 1'b0)
		else $error("busy raised");
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> ##(DVL+1) done)
		else $error("result lost");
	a_root_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ##(SQL) sq_valid)
		else $error("root pipe slip");
	a_newton_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cfg_q.newton, DVL+SQL+9))
		|-> (apply_first && apply_second))
		else $error("apply flags");
`endif
endmodule
`default_nettype wire

/* rtl/hbf_isqrt.sv */
// ----------------------------------------------------------------------------
// hbf_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module hbf_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [63:0] rsq,
	output logic             out_valid,
	output logic [31:0]      root
);
	import hbf_pkg::*;

	logic [SQ_STEPS:0]      v_q;
	logic [63:0]            x_q   [SQ_STEPS+1];
	logic [31:0]            r_q   [SQ_STEPS+1];

	always_comb begin
		x_q[0] = rsq;
		r_q[0] = '0;
	end

	assign v_q[0] = in_valid;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
		localparam int B = SQ_STEPS - 1 - i;
		logic [63:0] trial;
		logic [63:0] x_s1;
		logic [31:0] r_s1;
		logic        v_s1;
		assign trial = ({32'd0, r_q[i]} << (B + 1)) | (64'd1 << (2 * B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
			end else begin
				v_s1 <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (x_q[i] >= trial) begin
				x_s1 <= x_q[i] - trial;
				r_s1 <= r_q[i] | (32'd1 << B);
			end else begin
				x_s1 <= x_q[i];
				r_s1 <= r_q[i];
			end
		end
		assign v_q[i+1] = v_s1;
		assign x_q[i+1] = x_s1;
		assign r_q[i+1] = r_s1;
	end

	assign out_valid = v_q[SQ_STEPS];
	assign root      = r_q[SQ_STEPS];
endmodule
`default_nettype wire

/* rtl/hbf_rdiv.sv */
// ----------------------------------------------------------------------------
// hbf_rdiv
// pipelined rounded divider, one quotient bit per stage, saturating output
// ----------------------------------------------------------------------------
`default_nettype none
module hbf_rdiv (
	input  wire logic                clk,
	input  wire hbf_pkg::div_job_t   job,
	output logic [31:0]              quot
);
	import hbf_pkg::*;

	logic [63:0] rem_q [DIV_BITS+1];
	logic [63:0] lo_q  [DIV_BITS+1];
	logic [63:0] q_q   [DIV_BITS+1];
	logic [63:0] d_q   [DIV_BITS+1];
	logic        ov_q  [DIV_BITS+1];
	logic        ng_q  [DIV_BITS+1];
	logic        z_q   [DIV_BITS+1];
	logic [127:0] nr;

	always_comb begin
		nr       = job.num + {65'd0, job.den[63:1]};
		rem_q[0] = nr[127:64];
		lo_q[0]  = nr[63:0];
		q_q[0]   = '0;
		d_q[0]   = job.den;
		ov_q[0]  = (nr[127:64] >= job.den);
		ng_q[0]  = job.neg;
		z_q[0]   = job.zero;
	end

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
		logic [64:0] sh;
		assign sh = {rem_q[i], lo_q[i][63]};
		always_ff @(posedge clk) begin
			if (sh >= {1'b0, d_q[i]}) begin
				rem_q[i+1] <= 64'(sh - {1'b0, d_q[i]});
				q_q[i+1]   <= {q_q[i][62:0], 1'b1};
			end else begin
				rem_q[i+1] <= sh[63:0];
				q_q[i+1]   <= {q_q[i][62:0], 1'b0};
			end
			lo_q[i+1] <= {lo_q[i][62:0], 1'b0};
			d_q[i+1]  <= d_q[i];
			ov_q[i+1] <= ov_q[i];
			ng_q[i+1] <= ng_q[i];
			z_q[i+1]  <= z_q[i];
		end
	end

	always_comb begin
		if (z_q[DIV_BITS]) quot = '0;
		else quot = sat32(ng_q[DIV_BITS],
			ov_q[DIV_BITS] ? 64'hFFFF_FFFF_FFFF_FFFF : q_q[DIV_BITS]);
	end
endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the harmonic bond force pipeline against a fixed-point predictor of
// force, apply flags, energy and virial over all register settings, using
// directed bonds, random bonds and random gaps on the bond channel
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hbf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 120;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] x1, y1, z1, x2, y2, z2;
		logic [30:0] k, r0;
		logic        loc1, loc2;
	} bond_t;

	typedef struct packed {
		logic [31:0] fx, fy, fz;
		logic        app1, app2;
		logic [30:0] energy;
		logic [31:0] vxx, vyy, vzz, vxy, vxz, vyz;
	} bond_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	bond_t bond = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_NEWTON;
	logic [31:0] cfg_data = '0;
	logic done;
	bond_result_t res;

	cfg_t shadow_cfg;
	bond_result_t expected_q[$];
	int errors = 0;
	int bonds_sent = 0;
	int results_seen = 0;
	int settings_seen = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	always #10 clk = ~clk;

	harmonic_bond_force DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(bond.x1), .first_y(bond.y1), .first_z(bond.z1),
		.second_x(bond.x2), .second_y(bond.y2), .second_z(bond.z2),
		.stiffness(bond.k), .rest_length(bond.r0),
		.first_is_local(bond.loc1), .second_is_local(bond.loc2),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done),
		.force_x(res.fx), .force_y(res.fy), .force_z(res.fz),
		.apply_first(res.app1), .apply_second(res.app2), .energy_tally(res.energy),
		.virial_xx(res.vxx), .virial_yy(res.vyy), .virial_zz(res.vzz),
		.virial_xy(res.vxy), .virial_xz(res.vxz), .virial_yz(res.vyz)
	);

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned acc = 0;
		longint unsigned bitv = 64'h4000_0000_0000_0000;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= acc + bitv) begin
				x -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	// rounded quotient, half away from zero on magnitudes, capped at 64 bits
	function automatic logic [63:0] round_quot(logic [127:0] num, logic [127:0] den);
		logic [127:0] q;
		q = (num + (den >> 1)) / den;
		return (q > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	function automatic logic [31:0] clamp_signed(logic negative, logic [63:0] m);
		if (negative) return (m >= 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];
		return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	function automatic bond_result_t bond_force(bond_t b, cfg_t cf);
		bond_result_t o;
		longint d;
		longint unsigned m[3];
		logic n[3];
		longint unsigned rsq = 0;
		longint unsigned r, adr, a;
		longint dr;
		logic drneg;
		int c;
		logic [31:0] f[3];
		logic [31:0] v[6];
		int pa[6] = '{0, 1, 2, 0, 0, 1};
		int pb[6] = '{0, 1, 2, 1, 2, 2};
		logic [63:0] e;
		for (int i = 0; i < 3; i++) begin
			case (i)
				0: d = longint'($signed(b.x1)) - longint'($signed(b.x2));
				1: d = longint'($signed(b.y1)) - longint'($signed(b.y2));
				default: d = longint'($signed(b.z1)) - longint'($signed(b.z2));
			endcase
			if (d > 64'sd2147483647) d = 64'sd2147483647;
			if (d < -64'sd2147483648) d = -64'sd2147483648;
			n[i] = d < 0;
			m[i] = n[i] ? -d : d;
			rsq += m[i] * m[i];
		end
		r = root_floor(rsq);
		dr = longint'(r) - longint'(b.r0);
		drneg = dr < 0;
		adr = drneg ? -dr : dr;
		a = longint'(b.k) * adr;
		c = cf.newton ? 2 : int'(b.loc1) + int'(b.loc2);
		for (int i = 0; i < 3; i++)
			f[i] = clamp_signed(drneg == n[i], (r == 0) ? 64'd0 :
				round_quot(128'(a) * 2 * m[i], 128'(r) << 16));
		o.fx = f[0];
		o.fy = f[1];
		o.fz = f[2];
		o.app1 = cf.newton | b.loc1;
		o.app2 = cf.newton | b.loc2;
		e = 0;
		if (cf.energy && c != 0)
			e = round_quot(128'(a) * adr, 128'(1) << ((c == 2) ? 32 : 33));
		o.energy = (e > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : e[30:0];
		for (int i = 0; i < 6; i++)
			v[i] = clamp_signed((n[pa[i]] != n[pb[i]]) == drneg,
				(cf.virial && c != 0 && r != 0) ?
				round_quot(128'(a) * (m[pa[i]] * m[pb[i]]),
					128'(r) << ((c == 2) ? 31 : 32)) : 64'd0);
		{o.vxx, o.vyy, o.vzz, o.vxy, o.vxz, o.vyz} = {v[0], v[1], v[2], v[3], v[4], v[5]};
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $realtime, name, exp_v, act_v);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		bond_result_t ex;
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result, expected none actual %h", $realtime, res);
			end else begin
				ex = expected_q.pop_front();
				check_field("force_x", ex.fx, res.fx);
				check_field("force_y", ex.fy, res.fy);
				check_field("force_z", ex.fz, res.fz);
				check_field("apply_first", ex.app1, res.app1);
				check_field("apply_second", ex.app2, res.app2);
				check_field("energy_tally", ex.energy, res.energy);
				check_field("virial_xx", ex.vxx, res.vxx);
				check_field("virial_yy", ex.vyy, res.vyy);
				check_field("virial_zz", ex.vzz, res.vzz);
				check_field("virial_xy", ex.vxy, res.vxy);
				check_field("virial_xz", ex.vxz, res.vxz);
				check_field("virial_yz", ex.vyz, res.vyz);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[harmonic_bond_force] ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		if (!gaps_on) return 0;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send_bond(bond_t b);
		int g;
		bond <= b;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(bond_force(b, shadow_cfg));
		bonds_sent++;
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic value);
		cfg_index <= idx;
		cfg_data <= {31'($urandom), value};
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_NEWTON: shadow_cfg.newton = value;
			REG_ENERGY: shadow_cfg.energy = value;
			REG_VIRIAL: shadow_cfg.virial = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(logic [2:0] s);
		wait_drained();
		write_reg(REG_NEWTON, s[2]);
		write_reg(REG_ENERGY, s[1]);
		write_reg(REG_VIRIAL, s[0]);
		settings_seen++;
	endtask

	function automatic bond_t random_bond();
		bond_t b;
		int shape;
		logic [31:0] base;
		b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			31'($urandom), 31'($urandom), 2'($urandom)};
		shape = $urandom_range(9);
		if (shape < 5) begin
			// realistic bond: atoms close together, moderate constants
			base = $urandom;
			b.x2 = b.x1 + $signed(32'($urandom_range(0, 32'h0006_0000))) - 32'h0003_0000;
			b.y2 = b.y1 + $signed(32'($urandom_range(0, 32'h0006_0000))) - 32'h0003_0000;
			b.z2 = base + $signed(32'($urandom_range(0, 32'h0006_0000))) - 32'h0003_0000;
			b.z1 = base;
			b.k = 31'($urandom_range(0, 32'h0100_0000));
			b.r0 = 31'($urandom_range(0, 32'h0004_0000));
		end else if (shape == 5) begin
			b.x2 = b.x1;
			b.y2 = b.y1;
			b.z2 = b.z1;
		end else if (shape == 6) begin
			b.k = 31'($urandom_range(0, 32'h0001_0000));
		end
		return b;
	endfunction

	task automatic test_directed();
		bond_t b;
		b = '0;
		b.k = 31'h0001_0000;
		b.r0 = 31'h0001_0000;
		b.loc1 = 1'b1;
		b.loc2 = 1'b1;
		send_bond(b);                       // zero distance, energy from rest length
		b.x1 = 32'h0002_0000;
		send_bond(b);                       // stretched along x
		b.x1 = 32'h0000_8000;
		send_bond(b);                       // compressed
		b.x1 = 32'h0001_0000;
		send_bond(b);                       // at rest
		b = '{x1: 32'h7FFF_FFFF, y1: 32'h7FFF_FFFF, z1: 32'h7FFF_FFFF,
			x2: 32'h8000_0000, y2: 32'h8000_0000, z2: 32'h8000_0000,
			k: 31'h7FFF_FFFF, r0: 31'h0, loc1: 1'b1, loc2: 1'b0};
		send_bond(b);                       // delta saturation, max stiffness
		b = '{x1: 32'h8000_0000, y1: 32'h0, z1: 32'h7FFF_FFFF,
			x2: 32'h7FFF_FFFF, y2: 32'hFFFF_FFFF, z2: 32'h8000_0000,
			k: 31'h7FFF_FFFF, r0: 31'h7FFF_FFFF, loc1: 1'b0, loc2: 1'b1};
		send_bond(b);
		b = '{x1: 32'h0000_0001, y1: 32'hFFFF_FFFF, z1: 32'h0,
			x2: 32'h0, y2: 32'h0, z2: 32'h0000_0001,
			k: 31'h7FFF_FFFF, r0: 31'h7FFF_FFFF, loc1: 1'b0, loc2: 1'b0};
		send_bond(b);                       // tiny r, neither atom local
		b = '{x1: 32'h0003_0000, y1: 32'hFFFC_0000, z1: 32'h0001_8000,
			x2: 32'h0, y2: 32'h0, z2: 32'h0,
			k: 31'h0, r0: 31'h0002_0000, loc1: 1'b1, loc2: 1'b0};
		send_bond(b);                       // zero stiffness
		for (int i = 0; i < 6; i++) send_bond(random_bond());
	endtask

	task automatic test_settings();
		logic [2:0] order[8] = '{3'b000, 3'b111, 3'b011, 3'b100, 3'b010, 3'b001,
			3'b110, 3'b101};
		foreach (order[s]) begin
			apply_setting(order[s]);
			write_reg(REG_UNUSED, 1'b0);        // unused index, ignored
			gaps_on = (s != 1);
			for (int i = 0; i < 45; i++) send_bond(random_bond());
			gaps_on = 1'b1;
			for (int i = 0; i < 40; i++) send_bond(random_bond());
		end
	endtask

	task automatic test_pause();
		for (int i = 0; i < 10; i++) send_bond(random_bond());
		wait_drained();
		for (int i = 0; i < 10; i++) send_bond(random_bond());
	endtask

	initial begin
		shadow_cfg = '{newton: 1'b1, energy: 1'b0, virial: 1'b0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		apply_setting(3'b011);
		test_directed();
		apply_setting(3'b111);
		test_directed();
		test_settings();
		test_pause();
		wait_drained();
		if (expected_q.size() != 0) errors++;
		$display("bonds %0d, results %0d, register settings %0d incl. all flag combinations",
			bonds_sent, results_seen, settings_seen);
		if (errors == 0) begin
			$display("[harmonic_bond_force] OK");
		end else begin
			$display("[harmonic_bond_force] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
